FILE: sv/bmp_stream_writer_core_defines.svh
// Assertion macros for the BMP stream writer.
// Used by the top level only; expects clk and rst in the enclosing scope.
`ifndef BMP_STREAM_WRITER_CORE_DEFINES_SVH
`define BMP_STREAM_WRITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BSW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define BSW_ASSERT(lbl, prop, msg)
`define BSW_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: sv/bmp_sw_pkg.sv
// Shared types, constants and the microcode table of the BMP stream writer.
// No dependencies; the frame, sequencer, datapath, core and bench refer to it by scoped names.
`default_nettype none
package bmp_sw_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;
  localparam int CFG_W     = 13;
  localparam int STEP_W    = 6;
  localparam int HDR_BYTES = 54;
  localparam int ROWB_W    = 15;
  localparam int PROD_W    = 28;

  localparam logic [7:0] HDR_B       = 8'h42;
  localparam logic [7:0] HDR_M       = 8'h4D;
  localparam logic [7:0] HDR_OFFSET  = 8'd54;
  localparam logic [7:0] INFO_SIZE   = 8'd40;
  localparam logic [7:0] PLANES      = 8'd1;
  localparam logic [7:0] BPP         = 8'd24;
  localparam logic [7:0] MID_LEVEL   = 8'd127;

  localparam logic [STEP_W-1:0] UC_PIXEL = 6'd54;
  localparam logic [STEP_W-1:0] UC_PAD   = 6'd57;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_CONTRAST = 2'd2;

  typedef enum logic [2:0] {
    SRC_CONST, SRC_SIZE, SRC_WIDTH, SRC_HEIGHT,
    SRC_BLUE, SRC_GREEN, SRC_RED, SRC_PAD
  } src_t;

  typedef enum logic [1:0] {
    OP_NEXT, OP_PIXEL_END, OP_PAD_LOOP
  } op_t;

  typedef struct packed {
    src_t       src;
    logic [1:0] lane;
    logic [7:0] value;
    op_t        op;
  } ucode_t;

  typedef struct packed {
    logic       load;
    src_t       src;
    logic [1:0] lane;
    logic [7:0] value;
    logic       run_last;
    logic       frame_last;
  } ctl_t;

  typedef struct packed {
    logic       with_header;
    logic       frame_end;
    logic [1:0] pad;
  } info_t;

  typedef struct packed {
    logic [31:0]      size;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } hdr_t;

  function automatic logic [7:0] contrast_map(logic [7:0] v, logic en);
    logic [8:0] s;
    s = {1'b0, v} + 9'd255;
    if (!en) return v;
    if (v < MID_LEVEL) return {1'b0, v[7:1]};
    return s[8:1];
  endfunction

  function automatic logic [7:0] byte_of(logic [31:0] w, logic [1:0] lane);
    return w[{lane, 3'b000} +: 8];
  endfunction

  // One control word per output byte: 54 header steps, three pixel steps,
  // then a padding step that repeats.
  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] pc);
    ucode_t uc;
    uc = '{src: SRC_CONST, lane: 2'd0, value: 8'd0, op: OP_NEXT};
    case (pc)
      6'd0:  uc.value = HDR_B;
      6'd1:  uc.value = HDR_M;
      6'd2, 6'd3, 6'd4, 6'd5: begin
        uc.src  = SRC_SIZE;
        uc.lane = 2'(pc - 6'd2);
      end
      6'd10: uc.value = HDR_OFFSET;
      6'd14: uc.value = INFO_SIZE;
      6'd18, 6'd19, 6'd20, 6'd21: begin
        uc.src  = SRC_WIDTH;
        uc.lane = 2'(pc - 6'd18);
      end
      6'd22, 6'd23, 6'd24, 6'd25: begin
        uc.src  = SRC_HEIGHT;
        uc.lane = 2'(pc - 6'd22);
      end
      6'd26: uc.value = PLANES;
      6'd28: uc.value = BPP;
      6'd54: uc.src = SRC_BLUE;
      6'd55: uc.src = SRC_GREEN;
      6'd56: begin
        uc.src = SRC_RED;
        uc.op  = OP_PIXEL_END;
      end
      6'd57: begin
        uc.src = SRC_PAD;
        uc.op  = OP_PAD_LOOP;
      end
      default: uc.value = 8'd0;
    endcase
    return uc;
  endfunction

endpackage
`default_nettype wire

FILE: sv/bmp_sw_ifs.sv
// Valid/ready channel interfaces: pixels in, file bytes out.
// No dependencies.
`default_nettype none
interface bmp_sw_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface bmp_sw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_last;
  modport source (output valid, output out_byte, output run_last, output frame_last,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_last,
                output ready);
endinterface
`default_nettype wire

FILE: sv/bmp_sw_frame.sv
// Configuration registers, frame position counters and header field values.
// Depends on bmp_sw_pkg.
`default_nettype none
module bmp_sw_frame #(
  parameter int MaxDim = bmp_sw_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [bmp_sw_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                         accept,
  output bmp_sw_pkg::info_t                 info,
  output bmp_sw_pkg::hdr_t                  hdr,
  output logic                              contrast
);
  localparam int CntW = $clog2(MaxDim);
  localparam int CW   = bmp_sw_pkg::CFG_W;

  logic [CW-1:0]                   width_reg, height_reg;
  logic [CW-1:0]                   eff_w, eff_h;
  logic [bmp_sw_pkg::ROWB_W-1:0]   row_bytes;
  logic [bmp_sw_pkg::PROD_W-1:0]   prod;
  logic [31:0]                     size;
  logic [CntW-1:0]                 col, row;
  logic                            row_end, frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= CW'(1);
      height_reg <= CW'(1);
      contrast   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bmp_sw_pkg::CFG_WIDTH:    width_reg  <= cfg_data;
        bmp_sw_pkg::CFG_HEIGHT:   height_reg <= cfg_data;
        bmp_sw_pkg::CFG_CONTRAST: contrast   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp dimensions to 1..MaxDim
  always_comb begin
    if (width_reg == '0) eff_w = CW'(1);
    else if (32'(width_reg) > 32'(MaxDim)) eff_w = CW'(MaxDim);
    else eff_w = width_reg;
    if (height_reg == '0) eff_h = CW'(1);
    else if (32'(height_reg) > 32'(MaxDim)) eff_h = CW'(MaxDim);
    else eff_h = height_reg;
  end

  assign prod = bmp_sw_pkg::PROD_W'(eff_h) * bmp_sw_pkg::PROD_W'(row_bytes);

  // size pipeline: row_bytes and then size are registered after a register write
  always_ff @(posedge clk) begin
    row_bytes <= bmp_sw_pkg::ROWB_W'(eff_w) * bmp_sw_pkg::ROWB_W'(3)
               + bmp_sw_pkg::ROWB_W'(eff_w[1:0]);
    size      <= 32'(prod) + 32'(bmp_sw_pkg::HDR_BYTES);
  end

  assign row_end   = (32'(col) + 32'd1) >= 32'(eff_w);
  assign frame_end = row_end && ((32'(row) + 32'd1) >= 32'(eff_h));

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        row <= frame_end ? '0 : row + CntW'(1);
      end else begin
        col <= col + CntW'(1);
      end
    end
  end

  assign info.with_header = (col == '0) && (row == '0);
  assign info.frame_end   = frame_end;
  assign info.pad         = row_end ? eff_w[1:0] : 2'd0;
  assign hdr.size         = size;
  assign hdr.width        = eff_w;
  assign hdr.height       = eff_h;
endmodule
`default_nettype wire

FILE: sv/bmp_sw_seq.sv
// Microcode sequencer: step counter over the control table, pad loop counter.
// Depends on bmp_sw_pkg.
`default_nettype none
module bmp_sw_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire bmp_sw_pkg::info_t info,
  input  wire logic              load_ok,
  output bmp_sw_pkg::ctl_t       ctl,
  output logic                   busy,
  output logic                   done
);
  localparam int SW = bmp_sw_pkg::STEP_W;

  logic [SW-1:0]       pc, pc_next;
  logic                busy_next;
  logic [1:0]          pad_cnt, pad_cnt_next;
  logic [1:0]          pad_q;
  logic                frame_end_q;
  bmp_sw_pkg::ucode_t  uc;
  logic                adv, step_last;

  assign uc  = bmp_sw_pkg::ucode_rom(pc);
  assign adv = busy && load_ok;

  always_comb begin
    unique case (uc.op)
      bmp_sw_pkg::OP_PIXEL_END: step_last = (pad_q == 2'd0);
      bmp_sw_pkg::OP_PAD_LOOP:  step_last = (pad_cnt == 2'(pad_q - 2'd1));
      default:                  step_last = 1'b0;
    endcase
  end

  assign done = adv && step_last;

  always_comb begin
    pc_next      = pc;
    busy_next    = busy;
    pad_cnt_next = pad_cnt;
    if (start) begin
      pc_next      = info.with_header ? '0 : bmp_sw_pkg::UC_PIXEL;
      busy_next    = 1'b1;
      pad_cnt_next = 2'd0;
    end else if (adv) begin
      if (step_last) begin
        busy_next = 1'b0;
      end else begin
        unique case (uc.op)
          bmp_sw_pkg::OP_PIXEL_END: pc_next = bmp_sw_pkg::UC_PAD;
          bmp_sw_pkg::OP_PAD_LOOP:  pad_cnt_next = pad_cnt + 2'd1;
          default:                  pc_next = pc + SW'(1);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pc      <= '0;
      pad_cnt <= 2'd0;
    end else begin
      busy    <= busy_next;
      pc      <= pc_next;
      pad_cnt <= pad_cnt_next;
    end
  end

  // hold the per-pixel row/frame facts for the whole item
  always_ff @(posedge clk) begin
    if (start) begin
      pad_q       <= info.pad;
      frame_end_q <= info.frame_end;
    end
  end

  assign ctl.load       = adv;
  assign ctl.src        = uc.src;
  assign ctl.lane       = uc.lane;
  assign ctl.value      = uc.value;
  assign ctl.run_last   = step_last;
  assign ctl.frame_last = step_last && frame_end_q;
endmodule
`default_nettype wire

FILE: sv/bmp_sw_dp.sv
// Datapath: pixel capture with contrast mapping, byte select, output register.
// Depends on bmp_sw_pkg and the byte channel interface.
`default_nettype none
module bmp_sw_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       red,
  input  wire logic [7:0]       green,
  input  wire logic [7:0]       blue,
  input  wire logic             contrast,
  input  wire bmp_sw_pkg::hdr_t hdr,
  input  wire bmp_sw_pkg::ctl_t ctl,
  output logic                  load_ok,
  bmp_sw_byte_if.source         stream
);
  logic [7:0] red_q, green_q, blue_q;
  logic [7:0] sel_byte;

  always_ff @(posedge clk) begin
    if (accept) begin
      red_q   <= bmp_sw_pkg::contrast_map(red, contrast);
      green_q <= bmp_sw_pkg::contrast_map(green, contrast);
      blue_q  <= bmp_sw_pkg::contrast_map(blue, contrast);
    end
  end

  always_comb begin
    unique case (ctl.src)
      bmp_sw_pkg::SRC_CONST:  sel_byte = ctl.value;
      bmp_sw_pkg::SRC_SIZE:   sel_byte = bmp_sw_pkg::byte_of(hdr.size, ctl.lane);
      bmp_sw_pkg::SRC_WIDTH:  sel_byte = bmp_sw_pkg::byte_of(32'(hdr.width), ctl.lane);
      bmp_sw_pkg::SRC_HEIGHT: sel_byte = bmp_sw_pkg::byte_of(32'(hdr.height), ctl.lane);
      bmp_sw_pkg::SRC_BLUE:   sel_byte = blue_q;
      bmp_sw_pkg::SRC_GREEN:  sel_byte = green_q;
      bmp_sw_pkg::SRC_RED:    sel_byte = red_q;
      default:                sel_byte = 8'd0;
    endcase
  end

  assign load_ok = !stream.valid || stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream.valid <= 1'b0;
    end else if (ctl.load) begin
      stream.valid <= 1'b1;
    end else if (stream.ready) begin
      stream.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      stream.out_byte   <= sel_byte;
      stream.run_last   <= ctl.run_last;
      stream.frame_last <= ctl.frame_last;
    end
  end
endmodule
`default_nettype wire

FILE: sv/bmp_stream_writer_core.sv
// Pixel stream to 24-bit BMP byte stream. The microcode step counter emits one
// byte per cycle from a registered output while ready does not stall it; after
// accept, a pixel's first byte passes the step register, then the output register.
// A pixel gives 3 bytes, plus 54 on opening a frame and width mod 4 at row end.
// Reset clears the row/column position and sets width 1, height 1, contrast
// off; no memory needs clearing.
`default_nettype none
`include "bmp_stream_writer_core_defines.svh"
module bmp_stream_writer_core #(
  parameter int MaxDim = bmp_sw_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  bmp_sw_pixel_if.sink                      pixel,
  bmp_sw_byte_if.source                     stream,
  input  wire logic                         cfg_write,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [bmp_sw_pkg::CFG_W-1:0] cfg_data
);
  bmp_sw_pkg::info_t info;
  bmp_sw_pkg::hdr_t  hdr;
  bmp_sw_pkg::ctl_t  ctl;
  logic              contrast;
  logic              accept, busy, done, load_ok;

  // take the next pixel on the same edge that its predecessor's last byte loads
  assign pixel.ready = !busy || done;
  assign accept      = pixel.valid && pixel.ready;

  bmp_sw_frame #(.MaxDim(MaxDim)) u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .info      (info),
    .hdr       (hdr),
    .contrast  (contrast)
  );

  bmp_sw_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .info    (info),
    .load_ok (load_ok),
    .ctl     (ctl),
    .busy    (busy),
    .done    (done)
  );

  bmp_sw_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .red      (pixel.red),
    .green    (pixel.green),
    .blue     (pixel.blue),
    .contrast (contrast),
    .hdr      (hdr),
    .ctl      (ctl),
    .load_ok  (load_ok),
    .stream   (stream)
  );

  `BSW_ASSERT(a_frame_last_ends_run, stream.valid && stream.frame_last |-> stream.run_last, "frame_last without run_last")
  `BSW_ASSERT_NEXT(a_accept_starts_seq, accept, busy, "sequencer idle after accept")
  `BSW_ASSERT_NEXT(a_header_first, accept && info.with_header, ctl.src == bmp_sw_pkg::SRC_CONST && ctl.value == bmp_sw_pkg::HDR_B, "frame does not open with header")
endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for bmp_stream_writer_core: drives pixels and register writes,
// predicts every byte of the BMP stream, and compares each byte as it leaves.
// Depends on bmp_sw_pkg, the channel interfaces in bmp_sw_ifs.sv, and the core.
module tb;

  localparam int         CFG_W        = bmp_sw_pkg::CFG_W;
  localparam logic [1:0] CFG_WIDTH    = bmp_sw_pkg::CFG_WIDTH;
  localparam logic [1:0] CFG_HEIGHT   = bmp_sw_pkg::CFG_HEIGHT;
  localparam logic [1:0] CFG_CONTRAST = bmp_sw_pkg::CFG_CONTRAST;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         PHASE_ITEMS  = 40;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_last;
  } file_byte_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [1:0]       index;
    logic [CFG_W-1:0] value;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             known;
    logic [23:0]      bgr;
  } plan_row_t;

  localparam int PLAN_LEN = 31;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset values: 1x1 frame, contrast off
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h11, 8'h22, 8'h33, 1'b1, 24'h332211},
    '{ROW_WRITE, CFG_CONTRAST, 13'd1,    8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h00, 8'h7e, 8'hff, 1'b1, 24'hff3f00},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h7f, 8'h80, 8'h01, 1'b1, 24'h00bfbf},
    '{ROW_WRITE, CFG_UNUSED,   13'h1fff, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_WRITE, CFG_WIDTH,    13'd0,    8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_WRITE, CFG_HEIGHT,   13'h1fff, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'hff, 8'hff, 8'hff, 1'b1, 24'hffffff},
    // shrink the height mid-frame: this row closes the frame
    '{ROW_WRITE, CFG_HEIGHT,   13'd0,    8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h12, 8'h34, 8'h56, 1'b0, 24'h000000},
    '{ROW_WRITE, CFG_CONTRAST, 13'h1ffe, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_WRITE, CFG_WIDTH,    13'd4096, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_WRITE, CFG_HEIGHT,   13'd4096, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h5a, 8'ha5, 8'h3c, 1'b1, 24'h3ca55a},
    '{ROW_WRITE, CFG_WIDTH,    13'h1fff, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h80, 8'h7f, 8'h01, 1'b1, 24'h017f80},
    // narrow the row below the current column, then finish the frame
    '{ROW_WRITE, CFG_WIDTH,    13'd2,    8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'hc3, 8'h96, 8'h69, 1'b0, 24'h000000},
    '{ROW_WRITE, CFG_HEIGHT,   13'd2,    8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h01, 8'h02, 8'h04, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h08, 8'h10, 8'h20, 1'b0, 24'h000000},
    '{ROW_WRITE, CFG_WIDTH,    13'd3,    8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_WRITE, CFG_HEIGHT,   13'd1,    8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h40, 8'h80, 8'hfe, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'hfd, 8'hfb, 8'hf7, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'hef, 8'hdf, 8'hbf, 1'b0, 24'h000000},
    '{ROW_WRITE, CFG_WIDTH,    13'd4,    8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h7f, 8'h00, 8'h80, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h55, 8'haa, 8'h55, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'haa, 8'h55, 8'haa, 1'b0, 24'h000000},
    '{ROW_PIXEL, CFG_WIDTH,    13'd0,    8'h0f, 8'hf0, 8'hcc, 1'b0, 24'h000000}
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bmp_sw_pixel_if pixel_ch ();
  bmp_sw_byte_if  byte_ch ();

  bmp_stream_writer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel_ch),
    .stream    (byte_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers and the stream position
  logic [CFG_W-1:0] width_reg   = 13'd1;
  logic [CFG_W-1:0] height_reg  = 13'd1;
  logic             contrast_on = 1'b0;
  int unsigned      col_pos     = 0;
  int unsigned      row_pos     = 0;

  file_byte_t file_bytes_due[$];
  int         mismatches = 0;
  int         bytes_seen = 0;
  int         cycles     = 0;
  int         in_idle_pct;
  int         out_idle_pct;
  bit         write_open = 1'b0;
  logic       typed_known;
  logic [23:0] typed_bgr;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0d] mismatch: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > bmp_sw_pkg::MAX_DIM_DEFAULT) return bmp_sw_pkg::MAX_DIM_DEFAULT;
    return v;
  endfunction

  function automatic logic [7:0] stretch(logic [7:0] v);
    int unsigned t;
    t = v;
    if (!contrast_on) return v;
    if (v < bmp_sw_pkg::MID_LEVEL) return 8'(t / 2);
    return 8'((t + 255) / 2);
  endfunction

  // Work out every byte one pixel puts on the stream and queue them in order.
  function automatic void predict_file_bytes(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                             logic known, logic [23:0] bgr);
    logic [7:0]  seq[$];
    logic [7:0]  hdr [bmp_sw_pkg::HDR_BYTES];
    int unsigned w;
    int unsigned h;
    int unsigned pad;
    int unsigned size;
    logic        row_end;
    logic        frame_end;
    file_byte_t  fb;
    w   = clamp_dim(width_reg);
    h   = clamp_dim(height_reg);
    pad = w % 4;
    if (col_pos == 0 && row_pos == 0) begin
      size = bmp_sw_pkg::HDR_BYTES + h * (3 * w + pad);
      foreach (hdr[k]) hdr[k] = 8'd0;
      hdr[0]  = bmp_sw_pkg::HDR_B;
      hdr[1]  = bmp_sw_pkg::HDR_M;
      for (int k = 0; k < 4; k++) begin
        hdr[2 + k]  = 8'(size >> (8 * k));
        hdr[10 + k] = 8'(bmp_sw_pkg::HDR_BYTES >> (8 * k));
        hdr[18 + k] = 8'(w >> (8 * k));
        hdr[22 + k] = 8'(h >> (8 * k));
      end
      hdr[14] = bmp_sw_pkg::INFO_SIZE;
      hdr[26] = bmp_sw_pkg::PLANES;
      hdr[28] = bmp_sw_pkg::BPP;
      foreach (hdr[k]) seq.push_back(hdr[k]);
    end
    if (known) begin
      seq.push_back(bgr[23:16]);
      seq.push_back(bgr[15:8]);
      seq.push_back(bgr[7:0]);
    end else begin
      seq.push_back(stretch(b));
      seq.push_back(stretch(g));
      seq.push_back(stretch(r));
    end
    row_end   = (col_pos + 1) >= w;
    frame_end = row_end && ((row_pos + 1) >= h);
    if (row_end) begin
      repeat (pad) seq.push_back(8'd0);
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    foreach (seq[k]) begin
      fb.data       = seq[k];
      fb.run_last   = (k == seq.size() - 1);
      fb.frame_last = fb.run_last && frame_end;
      file_bytes_due.push_back(fb);
    end
  endfunction

  // Check leaving bytes first, then predict for a pixel taken at the same edge.
  always @(posedge clk) begin
    file_byte_t due;
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (file_bytes_due.size() == 0) begin
          report_mismatch($sformatf("byte %0d: %h with nothing due", bytes_seen,
                                    byte_ch.out_byte));
        end else begin
          due = file_bytes_due.pop_front();
          if (byte_ch.out_byte !== due.data)
            report_mismatch($sformatf("byte %0d: out_byte %h, want %h", bytes_seen,
                                      byte_ch.out_byte, due.data));
          if (byte_ch.run_last !== due.run_last)
            report_mismatch($sformatf("byte %0d: run_last %b, want %b", bytes_seen,
                                      byte_ch.run_last, due.run_last));
          if (byte_ch.frame_last !== due.frame_last)
            report_mismatch($sformatf("byte %0d: frame_last %b, want %b", bytes_seen,
                                      byte_ch.frame_last, due.frame_last));
        end
        bytes_seen++;
      end
      if (pixel_ch.valid && pixel_ch.ready)
        predict_file_bytes(pixel_ch.red, pixel_ch.green, pixel_ch.blue, typed_known,
                           typed_bgr);
    end
  end

  always @(posedge clk) begin
    byte_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic close_write();
    if (write_open) begin
      cfg_write  <= 1'b0;
      write_open = 1'b0;
    end
  endtask

  // Hold the write enable high; the next idle or pixel task drops it.
  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
    cfg_write  <= 1'b1;
    cfg_index  <= idx;
    cfg_data   <= value;
    write_open = 1'b1;
    case (idx)
      CFG_WIDTH:    width_reg = value;
      CFG_HEIGHT:   height_reg = value;
      CFG_CONTRAST: contrast_on = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop valid and wait until every predicted byte has left.
  task automatic wait_idle();
    pixel_ch.valid <= 1'b0;
    close_write();
    do @(negedge clk); while (file_bytes_due.size() != 0);
    @(posedge clk);
  endtask

  // Valid stays high after the item is taken, so back-to-back items toggle it only when a random idle gap is drawn.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic known,
                            logic [23:0] bgr);
    int gap;
    gap = 0;
    close_write();
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.red   <= r;
    pixel_ch.green <= g;
    pixel_ch.blue  <= b;
    typed_known    <= known;
    typed_bgr      <= bgr;
    do @(posedge clk); while (!pixel_ch.ready);
  endtask

  function automatic logic [7:0] pick_channel();
    logic [7:0] corner [5] = '{8'd0, 8'd126, 8'd127, 8'd128, 8'd255};
    if ($urandom_range(5) == 0) return corner[$urandom_range(4)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim(int unsigned top);
    if ($urandom_range(9) == 0) return CFG_W'($urandom);
    return CFG_W'($urandom_range(top));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned count;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.red   = '0;
    pixel_ch.green = '0;
    pixel_ch.blue  = '0;
    byte_ch.ready  = 1'b0;
    typed_known    = 1'b0;
    typed_bgr      = '0;
    in_idle_pct    = 23;
    out_idle_pct   = 55;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(PLAN[i].index, PLAN[i].value);
      end else begin
        send_pixel(PLAN[i].red, PLAN[i].green, PLAN[i].blue, PLAN[i].known, PLAN[i].bgr);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 23 : (phase == 1) ? 55 : 0;
      out_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 23 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        wait_idle();
        if ($urandom_range(9) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom));
        write_reg(CFG_WIDTH, pick_dim(9));
        write_reg(CFG_HEIGHT, pick_dim(4));
        write_reg(CFG_CONTRAST, CFG_W'($urandom));
        count = clamp_dim(width_reg) * clamp_dim(height_reg);
        // cut some frames short so the next settings land mid-frame
        if (count > 40) count = 40;
        if ($urandom_range(3) == 0) count = $urandom_range(count, 1);
        repeat (count) send_pixel(pick_channel(), pick_channel(), pick_channel(), 1'b0, '0);
        sent += count;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
